FILE: sv/tq_pkg.sv
// ----------------------------------------------------------------------------
// tq_pkg
// Shared types and constants of the grouped team queue.
// ----------------------------------------------------------------------------
`default_nettype none

package tq_pkg;

  localparam int POOL_ENTRIES_DEF = 1024;
  localparam int GROUP_COUNT_DEF  = 64;

  localparam int ELEM_W     = 16;
  localparam int GROUP_ID_W = 6;
  localparam int STATUS_W   = 2;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_PUSHED = 2'd0,
    ST_POPPED = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PUSH,
    S_POP_RING,
    S_POP_HEAD,
    S_POP_DONE
  } state_t;

endpackage

`default_nettype wire

FILE: sv/grouped_fifo_team_queue.sv
// ----------------------------------------------------------------------------
// grouped_fifo_team_queue
// Team queue: per-group FIFOs linked through a shared entry pool, groups
// served in the order in which they became non-empty.
// ----------------------------------------------------------------------------
//  channel | ports                                        | handshake
//  --------+----------------------------------------------+-----------------
//  in      | in_operation, in_elem_value, in_group_id     | in_valid/in_ready
//  out     | out_popped_value, out_status                 | out_valid/out_ready
//
//  a push is transferred, then allocates and links its entry; a pop walks
//  the chain of registered-read memories order ring -> group head/tail ->
//  entry value/link; a pop on an empty queue is answered in S_POP_RING.
//  one operation is in flight at a time, so no memory entry is read and
//  written at the same edge. reset clears the control registers and the
//  group busy bits only; the memories need no clearing pass.
//  a finished operation waits in its last state while the output register
//  still holds an untaken result.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_fifo_team_queue #(
  parameter int POOL_ENTRIES = tq_pkg::POOL_ENTRIES_DEF,
  parameter int GROUP_COUNT  = tq_pkg::GROUP_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_operation,
  input  wire logic [tq_pkg::ELEM_W-1:0]     in_elem_value,
  input  wire logic [tq_pkg::GROUP_ID_W-1:0] in_group_id,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [tq_pkg::ELEM_W-1:0]     out_popped_value,
  output logic      [tq_pkg::STATUS_W-1:0]   out_status
);

  import tq_pkg::*;

  localparam int PW = $clog2(POOL_ENTRIES);
  localparam int CW = $clog2(POOL_ENTRIES + 1);
  localparam int GW = $clog2(GROUP_COUNT);
  localparam int OW = $clog2(GROUP_COUNT + 1);

  // control registers
  state_t              state_r, state_nxt;
  logic [ELEM_W-1:0]   value_r, value_nxt;
  logic [GW-1:0]       group_r, group_nxt;
  logic [CW-1:0]       never_r, never_nxt;
  logic [PW-1:0]       rhead_r, rhead_nxt;
  logic [CW-1:0]       rcnt_r, rcnt_nxt;
  logic [GROUP_COUNT-1:0] busy_r, busy_nxt;
  logic [GW-1:0]       rp_r, rp_nxt;
  logic [GW-1:0]       wp_r, wp_nxt;
  logic [OW-1:0]       ocnt_r, ocnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [ELEM_W-1:0]   out_value_r, out_value_nxt;
  status_t             out_status_r, out_status_nxt;

  logic [GW-1:0] grp_w;
  logic          accept;
  logic          slot_ok;

  // memory ports
  logic              value_we, value_re;
  logic [PW-1:0]     value_waddr, value_raddr;
  logic [ELEM_W-1:0] value_rd;
  logic              link_we, link_re;
  logic [PW-1:0]     link_waddr, link_raddr, link_wdata, link_rd;
  logic              head_we, head_re;
  logic [GW-1:0]     head_waddr, head_raddr;
  logic [PW-1:0]     head_wdata, head_rd;
  logic              tail_we, tail_re;
  logic [GW-1:0]     tail_waddr, tail_raddr;
  logic [PW-1:0]     tail_wdata, tail_rd;
  logic              ring_we, ring_re;
  logic [GW-1:0]     ring_waddr, ring_raddr, ring_wdata, ring_rd;

  logic [PW-1:0] alloc_e;
  logic          pool_full;

  tq_grp_wrap #(.GROUP_COUNT(GROUP_COUNT)) u_grp_wrap (
    .group_in  (in_group_id),
    .group_out (grp_w)
  );

  tq_ram #(.WIDTH(ELEM_W), .DEPTH(POOL_ENTRIES)) u_entry_value (
    .clk(clk), .we(value_we), .waddr(value_waddr), .wdata(value_r),
    .re(value_re), .raddr(value_raddr), .rdata(value_rd)
  );

  tq_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_entry_link (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .re(link_re), .raddr(link_raddr), .rdata(link_rd)
  );

  tq_ram #(.WIDTH(PW), .DEPTH(GROUP_COUNT)) u_group_head (
    .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
    .re(head_re), .raddr(head_raddr), .rdata(head_rd)
  );

  tq_ram #(.WIDTH(PW), .DEPTH(GROUP_COUNT)) u_group_tail (
    .clk(clk), .we(tail_we), .waddr(tail_waddr), .wdata(tail_wdata),
    .re(tail_re), .raddr(tail_raddr), .rdata(tail_rd)
  );

  tq_ram #(.WIDTH(GW), .DEPTH(GROUP_COUNT)) u_order_ring (
    .clk(clk), .we(ring_we), .waddr(ring_waddr), .wdata(ring_wdata),
    .re(ring_re), .raddr(ring_raddr), .rdata(ring_rd)
  );

  assign in_ready         = (state_r == S_IDLE);
  assign accept           = in_valid && in_ready;
  assign slot_ok          = !out_valid_r || out_ready;
  assign out_valid        = out_valid_r;
  assign out_popped_value = out_value_r;
  assign out_status       = out_status_r;

  // recycled entries go out before never-used ones
  assign pool_full = (rcnt_r == '0) && (never_r == CW'(POOL_ENTRIES));
  assign alloc_e   = (rcnt_r != '0) ? rhead_r : never_r[PW-1:0];

  function automatic logic [GW-1:0] ring_inc(input logic [GW-1:0] p);
    ring_inc = (p == GW'(GROUP_COUNT - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    state_nxt      = state_r;
    value_nxt      = value_r;
    group_nxt      = group_r;
    never_nxt      = never_r;
    rhead_nxt      = rhead_r;
    rcnt_nxt       = rcnt_r;
    busy_nxt       = busy_r;
    rp_nxt         = rp_r;
    wp_nxt         = wp_r;
    ocnt_nxt       = ocnt_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;

    value_we    = 1'b0;
    value_waddr = alloc_e;
    value_re    = 1'b0;
    value_raddr = head_rd;
    link_we     = 1'b0;
    link_waddr  = tail_rd;
    link_wdata  = alloc_e;
    link_re     = 1'b0;
    link_raddr  = (state_r == S_IDLE) ? rhead_r : head_rd;
    head_we     = 1'b0;
    head_waddr  = group_r;
    head_wdata  = alloc_e;
    head_re     = 1'b0;
    head_raddr  = ring_rd;
    tail_we     = 1'b0;
    tail_waddr  = group_r;
    tail_wdata  = alloc_e;
    tail_re     = 1'b0;
    tail_raddr  = (state_r == S_IDLE) ? grp_w : ring_rd;
    ring_we     = 1'b0;
    ring_waddr  = wp_r;
    ring_wdata  = group_r;
    ring_re     = 1'b0;
    ring_raddr  = rp_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          value_nxt = in_elem_value;
          group_nxt = grp_w;
          if (in_operation == OP_PUSH) begin
            // next recycled entry and the group's tail, both needed to link
            link_re   = 1'b1;
            tail_re   = 1'b1;
            state_nxt = S_PUSH;
          end else begin
            ring_re   = 1'b1;
            state_nxt = S_POP_RING;
          end
        end
      end

      S_PUSH: begin
        if (slot_ok) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = '0;
          state_nxt     = S_IDLE;
          if (pool_full) begin
            out_status_nxt = ST_FULL;
          end else begin
            out_status_nxt = ST_PUSHED;
            value_we       = 1'b1;
            if (rcnt_r != '0) begin
              rhead_nxt = link_rd;
              rcnt_nxt  = rcnt_r - 1'b1;
            end else begin
              never_nxt = never_r + 1'b1;
            end
            tail_we = 1'b1;
            if (!busy_r[group_r]) begin
              // group was empty: it joins the order ring
              busy_nxt[group_r] = 1'b1;
              head_we           = 1'b1;
              ring_we           = 1'b1;
              wp_nxt            = ring_inc(wp_r);
              ocnt_nxt          = ocnt_r + 1'b1;
            end else begin
              link_we = 1'b1;
            end
          end
        end
      end

      S_POP_RING: begin
        if (ocnt_r == '0) begin
          if (slot_ok) begin
            out_valid_nxt  = 1'b1;
            out_value_nxt  = '0;
            out_status_nxt = ST_EMPTY;
            state_nxt      = S_IDLE;
          end
        end else begin
          head_re   = 1'b1;
          tail_re   = 1'b1;
          state_nxt = S_POP_HEAD;
        end
      end

      S_POP_HEAD: begin
        value_re  = 1'b1;
        link_re   = 1'b1;
        state_nxt = S_POP_DONE;
      end

      S_POP_DONE: begin
        // ring_rd, head_rd and tail_rd still hold the front group's reads
        if (slot_ok) begin
          out_valid_nxt  = 1'b1;
          out_value_nxt  = value_rd;
          out_status_nxt = ST_POPPED;
          state_nxt      = S_IDLE;
          if (head_rd == tail_rd) begin
            busy_nxt[ring_rd] = 1'b0;
            rp_nxt            = ring_inc(rp_r);
            ocnt_nxt          = ocnt_r - 1'b1;
          end else begin
            head_we    = 1'b1;
            head_waddr = ring_rd;
            head_wdata = link_rd;
          end
          // freed entry goes onto the recycle list
          link_we    = 1'b1;
          link_waddr = head_rd;
          link_wdata = rhead_r;
          rhead_nxt  = head_rd;
          rcnt_nxt   = rcnt_r + 1'b1;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      never_r      <= '0;
      rhead_r      <= '0;
      rcnt_r       <= '0;
      busy_r       <= '0;
      rp_r         <= '0;
      wp_r         <= '0;
      ocnt_r       <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_PUSHED;
    end else begin
      state_r      <= state_nxt;
      never_r      <= never_nxt;
      rhead_r      <= rhead_nxt;
      rcnt_r       <= rcnt_nxt;
      busy_r       <= busy_nxt;
      rp_r         <= rp_nxt;
      wp_r         <= wp_nxt;
      ocnt_r       <= ocnt_nxt;
      out_valid_r  <= out_valid_nxt;
      out_status_r <= out_status_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r     <= value_nxt;
    group_r     <= group_nxt;
    out_value_r <= out_value_nxt;
  end

`ifndef ASSERT_OFF
  a_order_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= OW'(GROUP_COUNT))
    else $error("order count above group count");

  a_recycled_le_used: assert property (@(posedge clk) disable iff (!rst_n)
    rcnt_r <= never_r)
    else $error("more recycled entries than entries handed out");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (ocnt_r == '0) |-> (rp_r == wp_r))
    else $error("order ring empty but pointers differ");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !(value_we || link_we || head_we || tail_we || ring_we))
    else $error("memory write while idle");
`endif

endmodule

`default_nettype wire

FILE: sv/tq_ram.sv
// ----------------------------------------------------------------------------
// tq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // read data holds while no read is issued
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/tq_grp_wrap.sv
// ----------------------------------------------------------------------------
// tq_grp_wrap
// Reduces the incoming group number modulo the group count.
// ----------------------------------------------------------------------------
`default_nettype none

module tq_grp_wrap #(
  parameter int GROUP_COUNT = tq_pkg::GROUP_COUNT_DEF
) (
  input  wire logic [tq_pkg::GROUP_ID_W-1:0]    group_in,
  output logic      [$clog2(GROUP_COUNT)-1:0]   group_out
);

  import tq_pkg::*;

  localparam int GW = $clog2(GROUP_COUNT);
  localparam int TW = GW + GROUP_ID_W + 1;

  // restoring reduction, one conditional subtract per input bit
  always_comb begin
    logic [TW-1:0] v;
    logic [TW-1:0] step;
    v = TW'(group_in);
    for (int k = GROUP_ID_W - 1; k >= 0; k--) begin
      step = TW'(GROUP_COUNT) << k;
      if (v >= step) begin
        v = v - step;
      end
    end
    group_out = v[GW-1:0];
  end

endmodule

`default_nettype wire

FILE: bench/grouped_fifo_team_queue_tb.sv
// ----------------------------------------------------------------------------
// grouped_fifo_team_queue_tb
// Self-checking bench for the team queue. A short table of directed pushes
// and pops is followed by random traffic: a mixed phase around the empty
// queue, a push-heavy phase that fills the entry pool until pushes are
// refused, and a mixed phase near full. Typed table rows are checked against
// the table, others against a queue-of-groups bench model. The sender works
// in bursts and the receiver stalls at varying rates, with one long hold-off.
// ----------------------------------------------------------------------------
`default_nettype none

module grouped_fifo_team_queue_tb;
  import tq_pkg::*;

  localparam int POOL   = POOL_ENTRIES_DEF;
  localparam int GROUPS = GROUP_COUNT_DEF;
  localparam int SLOT_W = $clog2(POOL);
  localparam int RING_W = $clog2(GROUPS);

  localparam int CYCLE_LIMIT      = 600000;
  localparam int MIXED_HEAD_ITEMS = 200;
  localparam int MIXED_TAIL_ITEMS = 150;
  localparam int FULL_HITS_WANTED = 5;
  localparam int HOLD_OFF_AFTER   = 400;
  localparam int HOLD_OFF_CYCLES  = 400;
  localparam int DRAIN_CYCLES     = 10;
  localparam int NUM_DIR          = 21;

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    status_t           status;
  } team_result_t;

  typedef struct packed {
    op_t                   op;
    logic [ELEM_W-1:0]     value;
    logic [GROUP_ID_W-1:0] grp;
    logic                  typed;
    logic [ELEM_W-1:0]     want_value;
    status_t               want_status;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  in_operation = OP_PUSH;
  logic [ELEM_W-1:0]     in_elem_value = '0;
  logic [GROUP_ID_W-1:0] in_group_id = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ELEM_W-1:0]     out_popped_value;
  logic [STATUS_W-1:0]   out_status;

  // typed expectation that travels with the item on the input channel
  logic                  row_typed = 1'b0;
  logic [ELEM_W-1:0]     row_want_value = '0;
  status_t               row_want_status = ST_PUSHED;

  team_result_t op_results_due[$];
  int err_count = 0;
  int full_hits = 0;
  int results_seen = 0;
  int cycle_count = 0;
  int burst_left = 0;

  // bench copy of the queue state
  logic [ELEM_W-1:0]     slot_value [POOL];
  logic [SLOT_W-1:0]     slot_next [POOL];
  logic [SLOT_W:0]       fresh_used = '0;
  logic [SLOT_W-1:0]     free_head = '0;
  logic [SLOT_W:0]       free_count = '0;
  logic [SLOT_W-1:0]     grp_first [GROUPS];
  logic [SLOT_W-1:0]     grp_last [GROUPS];
  logic                  grp_active [GROUPS];
  logic [RING_W-1:0]     turn_ring [GROUPS];
  logic [RING_W-1:0]     turn_rd = '0;
  logic [RING_W-1:0]     turn_wr = '0;
  logic [RING_W:0]       turn_count = '0;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{OP_POP,  16'hFFFF, 6'd63, 1'b1, 16'h0000, ST_EMPTY},
    '{OP_PUSH, 16'hFFFF, 6'd63, 1'b1, 16'h0000, ST_PUSHED},
    '{OP_PUSH, 16'h0000, 6'd0,  1'b1, 16'h0000, ST_PUSHED},
    '{OP_PUSH, 16'h8001, 6'd63, 1'b1, 16'h0000, ST_PUSHED},
    '{OP_PUSH, 16'h7FFE, 6'd1,  1'b1, 16'h0000, ST_PUSHED},
    '{OP_POP,  16'h0000, 6'd0,  1'b1, 16'hFFFF, ST_POPPED},
    '{OP_POP,  16'hAAAA, 6'd0,  1'b1, 16'h8001, ST_POPPED},
    '{OP_PUSH, 16'h5555, 6'd63, 1'b1, 16'h0000, ST_PUSHED},
    '{OP_POP,  16'h5555, 6'd42, 1'b1, 16'h0000, ST_POPPED},
    '{OP_POP,  16'h0000, 6'd0,  1'b1, 16'h7FFE, ST_POPPED},
    '{OP_POP,  16'hFFFF, 6'd63, 1'b1, 16'h5555, ST_POPPED},
    '{OP_POP,  16'h1234, 6'd21, 1'b1, 16'h0000, ST_EMPTY},
    '{OP_PUSH, 16'h00FF, 6'd42, 1'b0, 16'h0000, ST_PUSHED},
    '{OP_PUSH, 16'hFF00, 6'd21, 1'b0, 16'h0000, ST_PUSHED},
    '{OP_PUSH, 16'h1357, 6'd42, 1'b0, 16'h0000, ST_PUSHED},
    '{OP_POP,  16'h0000, 6'd0,  1'b0, 16'h0000, ST_POPPED},
    '{OP_PUSH, 16'h2468, 6'd21, 1'b0, 16'h0000, ST_PUSHED},
    '{OP_POP,  16'h0000, 6'd0,  1'b0, 16'h0000, ST_POPPED},
    '{OP_POP,  16'h0000, 6'd0,  1'b0, 16'h0000, ST_POPPED},
    '{OP_POP,  16'h0000, 6'd0,  1'b0, 16'h0000, ST_POPPED},
    '{OP_POP,  16'hFFFF, 6'd63, 1'b1, 16'h0000, ST_EMPTY}
  };

  grouped_fifo_team_queue dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_elem_value    (in_elem_value),
    .in_group_id      (in_group_id),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_popped_value (out_popped_value),
    .out_status       (out_status)
  );

  always #1 clk = ~clk;

  initial begin
    for (int i = 0; i < GROUPS; i++) begin
      grp_active[i] = 1'b0;
    end
  end

  // one push or pop applied to the bench copy of the queue
  task automatic team_queue_step(input op_t op, input logic [ELEM_W-1:0] v,
                                 input logic [GROUP_ID_W-1:0] g,
                                 output team_result_t res);
    logic [SLOT_W-1:0] e;
    logic [RING_W-1:0] front;
    res.value  = '0;
    res.status = ST_PUSHED;
    if (op == OP_PUSH) begin
      // recycled entries go out before never-used ones
      if (free_count != 0) begin
        e          = free_head;
        free_head  = slot_next[e];
        free_count = free_count - 1'b1;
      end else if (fresh_used < POOL) begin
        e          = fresh_used[SLOT_W-1:0];
        fresh_used = fresh_used + 1'b1;
      end else begin
        res.status = ST_FULL;
        return;
      end
      slot_value[e] = v;
      slot_next[e]  = '0;
      if (!grp_active[g]) begin
        grp_active[g]      = 1'b1;
        grp_first[g]       = e;
        grp_last[g]        = e;
        turn_ring[turn_wr] = g;
        turn_wr            = turn_wr + 1'b1;
        turn_count         = turn_count + 1'b1;
      end else begin
        slot_next[grp_last[g]] = e;
        grp_last[g]            = e;
      end
    end else begin
      if (turn_count == 0) begin
        res.status = ST_EMPTY;
        return;
      end
      front     = turn_ring[turn_rd];
      e         = grp_first[front];
      res.value = slot_value[e];
      res.status = ST_POPPED;
      if (e == grp_last[front]) begin
        grp_active[front] = 1'b0;
        turn_rd           = turn_rd + 1'b1;
        turn_count        = turn_count - 1'b1;
      end else begin
        grp_first[front] = slot_next[e];
      end
      slot_next[e] = free_head;
      free_head    = e;
      free_count   = free_count + 1'b1;
    end
  endtask

  always @(posedge clk) begin : scoreboard
    team_result_t due;
    team_result_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        team_queue_step(op_t'(in_operation), in_elem_value, in_group_id, due);
        if (row_typed) begin
          due.value  = row_want_value;
          due.status = row_want_status;
        end
        if (due.status == ST_FULL) begin
          full_hits++;
        end
        op_results_due.push_back(due);
      end
      if (out_valid && out_ready) begin
        results_seen++;
        got.value  = out_popped_value;
        got.status = status_t'(out_status);
        if (op_results_due.size() == 0) begin
          $display("%0t: result with none expected, value %h status %0d",
                   $time, got.value, got.status);
          err_count++;
        end else begin
          due = op_results_due.pop_front();
          if (got.value !== due.value) begin
            $display("%0t: popped_value expected %h got %h", $time, due.value, got.value);
            err_count++;
          end
          if (got.status !== due.status) begin
            $display("%0t: status expected %0d got %0d", $time, due.status, got.status);
            err_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // called at a falling edge; returns at the falling edge after the transfer
  task automatic offer_op(input op_t op, input logic [ELEM_W-1:0] v,
                          input logic [GROUP_ID_W-1:0] g, input logic typed,
                          input logic [ELEM_W-1:0] want_value, input status_t want_status);
    in_valid        <= 1'b1;
    in_operation    <= op;
    in_elem_value   <= v;
    in_group_id     <= g;
    row_typed       <= typed;
    row_want_value  <= want_value;
    row_want_status <= want_status;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // burst bookkeeping: a gap of random length once the burst runs out
  task automatic pace_sender();
    int gap;
    burst_left--;
    if (burst_left <= 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  task automatic offer_random(input int push_pct);
    op_t op;
    logic [GROUP_ID_W-1:0] g;
    logic [ELEM_W-1:0] v;
    op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
    // half the pushes land on a few hot groups so their lists grow long
    if ($urandom_range(0, 1) == 1) begin
      g = GROUP_ID_W'($urandom_range(0, GROUPS - 1));
    end else begin
      g = GROUP_ID_W'($urandom_range(0, 3) * 21);
    end
    v = ELEM_W'($urandom_range(0, 65535));
    offer_op(op, v, g, 1'b0, '0, ST_PUSHED);
    pace_sender();
  endtask

  // receiver: ready rate changes in stretches, one long hold-off
  initial begin : receiver
    int ready_pct;
    int mode_left;
    bit held_off;
    ready_pct = 100;
    mode_left = 0;
    held_off  = 1'b0;
    forever begin
      @(negedge clk);
      if (!held_off && results_seen >= HOLD_OFF_AFTER) begin
        held_off = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        if (mode_left == 0) begin
          mode_left = $urandom_range(20, 120);
          case ($urandom_range(0, 3))
            0: ready_pct = 100;
            1: ready_pct = 80;
            2: ready_pct = 40;
            default: ready_pct = 10;
          endcase
        end
        mode_left--;
        out_ready <= ($urandom_range(0, 99) < ready_pct);
      end
    end
  end

  initial begin
    burst_left = $urandom_range(1, 24);
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < NUM_DIR; i++) begin
      offer_op(dir_rows[i].op, dir_rows[i].value, dir_rows[i].grp, dir_rows[i].typed,
               dir_rows[i].want_value, dir_rows[i].want_status);
      pace_sender();
    end

    // around empty, then fill the pool until pushes bounce, then stay near full
    repeat (MIXED_HEAD_ITEMS) offer_random(50);
    while (full_hits < FULL_HITS_WANTED) offer_random(92);
    repeat (MIXED_TAIL_ITEMS) offer_random(55);

    in_valid <= 1'b0;
    while (op_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
